// ===== rtl/led_current_regulated_dimmer_macros.svh =====
// Assertion macros shared by the dimmer checker.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef LED_CURRENT_REGULATED_DIMMER_MACROS_SVH
`define LED_CURRENT_REGULATED_DIMMER_MACROS_SVH

// same-cycle implication, quiet during reset
`define LCRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define LCRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcrd_pkg.sv =====
// Shared constants, types and helpers for the LED dimmer.
// No dependencies; used by every other file of the block but the macro header.
package lcrd_pkg;

  localparam int KEY_POLL_TICKS = 50;
  localparam int SAMPLE_COUNT   = 8;
  localparam int SAMPLE_SHIFT   = 3;
  localparam int DUTY_MAX       = 255;

  localparam int CNT_W      = 16;
  localparam int DUTY_W     = 8;
  localparam int CUR_W      = 10;
  localparam int SUM_W      = 16;
  localparam int AVG_W      = SUM_W - SAMPLE_SHIFT;
  localparam int IDX_W      = $clog2(SAMPLE_COUNT + 2);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_CURRENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_MID_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_SLOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_MID       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_FAST      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_PERIOD  = 3'd7;

  // register reset values
  localparam logic [CUR_W-1:0]  NOMINAL_RST = 10'd512;
  localparam logic [DUTY_W-1:0] START_RST   = 8'd64;
  localparam logic [DUTY_W-1:0] LOW_TOP_RST = 8'd32;
  localparam logic [DUTY_W-1:0] MID_TOP_RST = 8'd128;
  localparam logic [CNT_W-1:0]  SLOW_RST    = 16'd20;
  localparam logic [CNT_W-1:0]  MID_RST     = 16'd10;
  localparam logic [CNT_W-1:0]  FAST_RST    = 16'd2;
  localparam logic [CNT_W-1:0]  PERIOD_RST  = 16'd100;

  localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};

  typedef struct packed {
    logic [CUR_W-1:0]  nominal_current;
    logic [DUTY_W-1:0] start_level;
    logic [DUTY_W-1:0] band_low_top;
    logic [DUTY_W-1:0] band_mid_top;
    logic [CNT_W-1:0]  dwell_slow;
    logic [CNT_W-1:0]  dwell_mid;
    logic [CNT_W-1:0]  dwell_fast;
    logic [CNT_W-1:0]  measure_period;
  } cfg_t;

  typedef struct packed {
    logic             tick;
    logic             key_down;
    logic             conv_done;
    logic [CUR_W-1:0] conv_value;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              drive_enabled;
    logic              lamp_on;
    logic              start_conversion;
    logic              sleep_now;
    logic [CUR_W-1:0]  average_current;
  } result_t;

  // saturating tick counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic en);
    if (en && (c != {CNT_W{1'b1}})) begin
      return c + CNT_W'(1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/lcrd_ifs.sv =====
// Handshake channel interfaces for the LED dimmer: item, result, register write.
// Depends on lcrd_pkg.
interface lcrd_item_if;
  logic                      valid;
  logic                      ready;
  logic                      tick;
  logic                      key_down;
  logic                      conv_done;
  logic [lcrd_pkg::CUR_W-1:0] conv_value;
  modport source (output valid, tick, key_down, conv_done, conv_value, input ready);
  modport sink   (input valid, tick, key_down, conv_done, conv_value, output ready);
endinterface

interface lcrd_result_if;
  logic                       valid;
  logic                       ready;
  logic [lcrd_pkg::DUTY_W-1:0] duty;
  logic                       drive_enabled;
  logic                       lamp_on;
  logic                       start_conversion;
  logic                       sleep_now;
  logic [lcrd_pkg::CUR_W-1:0]  average_current;
  modport source (output valid, duty, drive_enabled, lamp_on, start_conversion, sleep_now,
                  average_current, input ready);
  modport sink   (input valid, duty, drive_enabled, lamp_on, start_conversion, sleep_now,
                  average_current, output ready);
endinterface

interface lcrd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lcrd_pkg::CFG_IDX_W-1:0]  index;
  logic [lcrd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/led_current_regulated_dimmer.sv =====
// Top level of the current-regulated LED dimmer.
// Depends on lcrd_pkg, lcrd_ifs, lcrd_cfg and lcrd_loop.

// Each transaction on in_item is one pass of the dimmer's control loop and
// yields exactly one transaction on out_res. A pass goes through an input
// register, one pass of combinational loop logic and a result register. The
// block therefore takes one transaction per clock cycle while the receiver
// keeps out_res ready. A result is offered on out_res once its item has
// passed the input register and its result the result register. That rate
// comes from the loop state being updated in one pass of logic. The result
// register sits between the input and output handshakes. While a finished
// result waits, the input register can still take one item. The loop only
// advances when the result register can take its output. Settings are
// written through cfg_wr, which is always ready, and must only change while
// no transaction is in flight. After reset the lamp counts as on and aims for
// the start level, with all settings at their documented defaults.
module led_current_regulated_dimmer (
  input  logic                 clk,
  input  logic                 rst_n,
  lcrd_item_if.sink            in_item,
  lcrd_result_if.source        out_res,
  lcrd_cfg_if.sink             cfg_wr
);

  lcrd_pkg::cfg_t    cfg;
  lcrd_pkg::item_t   item_r;
  lcrd_pkg::result_t res_comb;
  lcrd_pkg::result_t res_r;
  logic              in_valid_r, in_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              advance;
  logic              in_take;

  // register writes are always accepted and take effect in the next cycle
  assign cfg_wr.ready = 1'b1;

  lcrd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr.valid),
    .wr_idx  (cfg_wr.index),
    .wr_data (cfg_wr.data),
    .cfg     (cfg)
  );

  // loop steps when an item is held and the result slot is free or draining
  assign advance       = in_valid_r && (!out_valid_r || out_res.ready);
  assign in_item.ready = !in_valid_r || advance;
  assign in_take       = in_item.valid && in_item.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.tick       <= in_item.tick;
      item_r.key_down   <= in_item.key_down;
      item_r.conv_done  <= in_item.conv_done;
      item_r.conv_value <= in_item.conv_value;
    end
    if (advance) begin
      res_r <= res_comb;
    end
  end

  lcrd_loop u_loop (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res_comb)
  );

  assign out_res.valid            = out_valid_r;
  assign out_res.duty             = res_r.duty;
  assign out_res.drive_enabled    = res_r.drive_enabled;
  assign out_res.lamp_on          = res_r.lamp_on;
  assign out_res.start_conversion = res_r.start_conversion;
  assign out_res.sleep_now        = res_r.sleep_now;
  assign out_res.average_current  = res_r.average_current;

endmodule

// ===== rtl/lcrd_cfg.sv =====
// Register file for the dimmer settings.
// Depends on lcrd_pkg.
module lcrd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [lcrd_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  logic [lcrd_pkg::CFG_DATA_W-1:0] wr_data,
  output lcrd_pkg::cfg_t                 cfg
);

  lcrd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal_current <= lcrd_pkg::NOMINAL_RST;
      cfg_r.start_level     <= lcrd_pkg::START_RST;
      cfg_r.band_low_top    <= lcrd_pkg::LOW_TOP_RST;
      cfg_r.band_mid_top    <= lcrd_pkg::MID_TOP_RST;
      cfg_r.dwell_slow      <= lcrd_pkg::SLOW_RST;
      cfg_r.dwell_mid       <= lcrd_pkg::MID_RST;
      cfg_r.dwell_fast      <= lcrd_pkg::FAST_RST;
      cfg_r.measure_period  <= lcrd_pkg::PERIOD_RST;
    end else if (wr_en) begin
      case (wr_idx)
        lcrd_pkg::REG_NOMINAL_CURRENT: cfg_r.nominal_current <= wr_data[lcrd_pkg::CUR_W-1:0];
        lcrd_pkg::REG_START_LEVEL:     cfg_r.start_level  <= wr_data[lcrd_pkg::DUTY_W-1:0];
        lcrd_pkg::REG_BAND_LOW_TOP:    cfg_r.band_low_top <= wr_data[lcrd_pkg::DUTY_W-1:0];
        lcrd_pkg::REG_BAND_MID_TOP:    cfg_r.band_mid_top <= wr_data[lcrd_pkg::DUTY_W-1:0];
        lcrd_pkg::REG_DWELL_SLOW:      cfg_r.dwell_slow     <= wr_data[lcrd_pkg::CNT_W-1:0];
        lcrd_pkg::REG_DWELL_MID:       cfg_r.dwell_mid      <= wr_data[lcrd_pkg::CNT_W-1:0];
        lcrd_pkg::REG_DWELL_FAST:      cfg_r.dwell_fast     <= wr_data[lcrd_pkg::CNT_W-1:0];
        lcrd_pkg::REG_MEASURE_PERIOD:  cfg_r.measure_period <= wr_data[lcrd_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/lcrd_loop.sv =====
// Control loop state and its one-pass update: key, fade, measurement, sleep.
// Depends on lcrd_pkg.
module lcrd_loop (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lcrd_pkg::item_t   item,
  input  lcrd_pkg::cfg_t    cfg,
  output lcrd_pkg::result_t res
);

  logic [lcrd_pkg::DUTY_W-1:0] duty_r, duty_nxt;
  logic [lcrd_pkg::DUTY_W-1:0] target_r, target_nxt;
  logic                        lamp_r, lamp_nxt;
  logic                        drive_r, drive_nxt;
  logic                        held_r, held_nxt;
  logic                        meas_r, meas_nxt;
  logic [lcrd_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [lcrd_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [lcrd_pkg::AVG_W-1:0]  avg_r, avg_nxt;
  logic [lcrd_pkg::CNT_W-1:0]  fade_cnt_r, fade_cnt_nxt;
  logic [lcrd_pkg::CNT_W-1:0]  meas_cnt_r, meas_cnt_nxt;
  logic [lcrd_pkg::CNT_W-1:0]  poll_cnt_r, poll_cnt_nxt;

  logic [lcrd_pkg::CNT_W-1:0]  dwell;
  logic                        step_ok;
  logic [lcrd_pkg::IDX_W-1:0]  idx_inc;
  logic [lcrd_pkg::SUM_W-1:0]  sum_add;
  logic [lcrd_pkg::SUM_W-1:0]  sum_avg;
  logic                        started;

  always_comb begin
    fade_cnt_nxt = lcrd_pkg::sat_inc(fade_cnt_r, item.tick);
    meas_cnt_nxt = lcrd_pkg::sat_inc(meas_cnt_r, item.tick);
    poll_cnt_nxt = lcrd_pkg::sat_inc(poll_cnt_r, item.tick);
    held_nxt     = held_r;
    lamp_nxt     = lamp_r;
    target_nxt   = target_r;
    duty_nxt     = duty_r;
    drive_nxt    = drive_r;
    meas_nxt     = meas_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    avg_nxt      = avg_r;
    started      = 1'b0;

    // key poll and edge detect
    if (poll_cnt_nxt >= lcrd_pkg::CNT_W'(lcrd_pkg::KEY_POLL_TICKS)) begin
      poll_cnt_nxt = '0;
      if (!held_r && item.key_down) begin
        held_nxt = 1'b1;
        if (lamp_r) begin
          lamp_nxt   = 1'b0;
          target_nxt = '0;
        end else begin
          lamp_nxt   = 1'b1;
          target_nxt = (duty_r > cfg.start_level) ? duty_r : cfg.start_level;
        end
      end else if (held_r && !item.key_down) begin
        held_nxt = 1'b0;
      end
    end

    // fade, dwell picked by the band of the present duty
    if (duty_r <= cfg.band_low_top) begin
      dwell = cfg.dwell_slow;
    end else if (duty_r <= cfg.band_mid_top) begin
      dwell = cfg.dwell_mid;
    end else begin
      dwell = cfg.dwell_fast;
    end
    step_ok = (fade_cnt_nxt >= dwell);

    if (duty_r != target_nxt) begin
      if (step_ok) begin
        fade_cnt_nxt = '0;
      end
      if (target_nxt < duty_r) begin
        if (step_ok) begin
          duty_nxt = duty_r - lcrd_pkg::DUTY_W'(1);
        end
        if (duty_nxt == '0) begin
          drive_nxt = 1'b0;
        end
      end else begin
        if (duty_r == '0) begin
          drive_nxt = 1'b1;
        end
        if (step_ok) begin
          duty_nxt = duty_r + lcrd_pkg::DUTY_W'(1);
        end
      end
    end

    // measurement series; first conversion is thrown away
    idx_inc = idx_r + lcrd_pkg::IDX_W'(1);
    sum_add = sum_r + ((idx_r != '0) ? lcrd_pkg::SUM_W'(item.conv_value) : '0);
    sum_avg = sum_add >> lcrd_pkg::SAMPLE_SHIFT;
    if (!meas_r) begin
      if (meas_cnt_nxt >= cfg.measure_period) begin
        meas_cnt_nxt = '0;
        idx_nxt      = '0;
        sum_nxt      = '0;
        meas_nxt     = 1'b1;
        started      = 1'b1;
      end
    end else if (item.conv_done) begin
      idx_nxt = idx_inc;
      sum_nxt = sum_add;
      if (idx_inc > lcrd_pkg::IDX_W'(lcrd_pkg::SAMPLE_COUNT)) begin
        meas_nxt     = 1'b0;
        meas_cnt_nxt = '0;
        sum_nxt      = sum_avg;
        avg_nxt      = sum_avg[lcrd_pkg::AVG_W-1:0];
        if (lamp_nxt) begin
          if ((avg_nxt > lcrd_pkg::AVG_W'(cfg.nominal_current)) && (target_nxt != '0)) begin
            target_nxt = target_nxt - lcrd_pkg::DUTY_W'(1);
          end
          if ((avg_nxt < lcrd_pkg::AVG_W'(cfg.nominal_current)) &&
              (target_nxt < lcrd_pkg::DUTY_W'(lcrd_pkg::DUTY_MAX))) begin
            target_nxt = target_nxt + lcrd_pkg::DUTY_W'(1);
          end
        end
      end
    end

    res.duty             = duty_nxt;
    res.drive_enabled    = drive_nxt;
    res.lamp_on          = lamp_nxt;
    res.start_conversion = started;
    res.sleep_now        = !lamp_nxt && (duty_nxt == '0) && !held_nxt;
    res.average_current  = (avg_nxt > lcrd_pkg::AVG_W'(lcrd_pkg::CUR_MAX)) ?
                           lcrd_pkg::CUR_MAX : avg_nxt[lcrd_pkg::CUR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= '0;
      target_r   <= lcrd_pkg::START_RST;
      lamp_r     <= 1'b1;
      drive_r    <= 1'b0;
      held_r     <= 1'b0;
      meas_r     <= 1'b0;
      idx_r      <= '0;
      sum_r      <= '0;
      avg_r      <= '0;
      fade_cnt_r <= '0;
      meas_cnt_r <= '0;
      poll_cnt_r <= '0;
    end else if (step) begin
      duty_r     <= duty_nxt;
      target_r   <= target_nxt;
      lamp_r     <= lamp_nxt;
      drive_r    <= drive_nxt;
      held_r     <= held_nxt;
      meas_r     <= meas_nxt;
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      avg_r      <= avg_nxt;
      fade_cnt_r <= fade_cnt_nxt;
      meas_cnt_r <= meas_cnt_nxt;
      poll_cnt_r <= poll_cnt_nxt;
    end
  end

endmodule

// ===== rtl/lcrd_checker.sv =====
// Port-level checks for the LED dimmer, bound onto the top level.
// Depends on lcrd_pkg and led_current_regulated_dimmer_macros.svh.
`include "led_current_regulated_dimmer_macros.svh"

module lcrd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lcrd_pkg::DUTY_W-1:0] duty,
  input logic                        drive_enabled,
  input logic                        lamp_on,
  input logic                        sleep_now
);

  logic [lcrd_pkg::DUTY_W-1:0] prev_duty_r;
  logic                        have_prev_r;
  logic                        duty_step_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_duty_r <= duty;
    end
  end

  // consecutive results move the duty by at most one step
  assign duty_step_ok = (duty == prev_duty_r) ||
                        ({1'b0, duty} == {1'b0, prev_duty_r} + 9'd1) ||
                        ({1'b0, prev_duty_r} == {1'b0, duty} + 9'd1);

  `LCRD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duty), "result dropped while stalled")
  `LCRD_ASSERT_IMP(a_duty_step, out_valid && have_prev_r, duty_step_ok, "duty jumped by more than one step")
  `LCRD_ASSERT_IMP(a_drive_on, out_valid && (duty != '0), drive_enabled, "duty above zero with drive off")
  `LCRD_ASSERT_IMP(a_sleep_ok, out_valid && sleep_now, !lamp_on && (duty == '0), "sleep with lamp on or duty above zero")

endmodule

bind led_current_regulated_dimmer lcrd_checker u_lcrd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .duty          (out_res.duty),
  .drive_enabled (out_res.drive_enabled),
  .lamp_on       (out_res.lamp_on),
  .sleep_now     (out_res.sleep_now)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for led_current_regulated_dimmer: a short directed table, then
// random control-loop passes over several register settings and handshake regimes.
// Depends on lcrd_pkg, the lcrd_ifs channel interfaces and the dimmer RTL.
module tb;
  import lcrd_pkg::*;

  // run shape
  localparam int PHASES          = 8;
  localparam int PHASE_PASSES    = 155;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DIR_ROWS        = 23;
  localparam int DIR_CFG_ROW     = 9;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one directed row; typed rows expect the frozen picture right after reset
  typedef struct packed {
    item_t stim;
    logic  typed;
  } dir_row_t;

  // duty 0, drive on (duty must rise towards 64), lamp on, no series, awake, no average
  localparam result_t AFTER_RESET = {8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0};

  // directed settings once the reset rows are done: every delay 0, so the fade
  // steps on every pass and a series opens when none runs; nominal and start at top
  localparam cfg_t DIR_SETTINGS = {10'd1023, 8'd255, 8'd0, 8'd255,
                                   16'd0, 16'd0, 16'd0, 16'd0};

  logic clk = 1'b0;
  logic rst_n;

  lcrd_item_if   item_ch ();
  lcrd_result_if res_ch ();
  lcrd_cfg_if    cfg_ch ();

  led_current_regulated_dimmer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_item(item_ch),
    .out_res(res_ch),
    .cfg_wr (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the dimmer: registers and loop state, stepped once per
  // accepted input transaction.
  // ---------------------------------------------------------------------------
  cfg_t              dimmer_regs;
  logic [DUTY_W-1:0] duty_level;
  logic [DUTY_W-1:0] duty_aim;
  logic              lamp_lit;
  logic              drive_run;
  logic              key_latched;
  logic              series_active;
  logic [4:0]        series_idx;    // runs to SAMPLE_COUNT + 1, so one bit spare
  logic [SUM_W-1:0]  series_sum;
  logic [CNT_W-1:0]  fade_ticks;
  logic [CNT_W-1:0]  series_ticks;
  logic [CNT_W-1:0]  poll_ticks;
  logic [SUM_W-1:0]  avg_reading;   // full width; the regulator compares all of it

  result_t     loop_results_due[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 0;        // sender: chance of an idle cycle before a pass
  int unsigned stall_pct = 0;       // receiver: chance of ready low in a cycle
  bit          hold_req = 1'b0;     // asks the receiver for one long hold-off
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  dir_row_t    dir_rows[DIR_ROWS];

  // The dwell for the present duty band has run out: restart the count.
  function automatic logic fade_dwell_over();
    logic [CNT_W-1:0] dwell;
    if (duty_level <= dimmer_regs.band_low_top) begin
      dwell = dimmer_regs.dwell_slow;
    end else if (duty_level <= dimmer_regs.band_mid_top) begin
      dwell = dimmer_regs.dwell_mid;
    end else begin
      dwell = dimmer_regs.dwell_fast;
    end
    if (fade_ticks >= dwell) begin
      fade_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One pass of the control loop: key, fade, measurement, then the sleep check.
  function automatic result_t control_loop_pass(input item_t it);
    result_t r;
    logic    started;
    started = 1'b0;

    // interval counters saturate rather than wrap
    if (it.tick && fade_ticks != '1) fade_ticks++;
    if (it.tick && series_ticks != '1) series_ticks++;
    if (it.tick && poll_ticks != '1) poll_ticks++;

    // key: sampled every KEY_POLL_TICKS, a fresh press toggles the lamp
    if (poll_ticks >= KEY_POLL_TICKS) begin
      poll_ticks = '0;
      if (!key_latched && it.key_down) begin
        key_latched = 1'b1;
        if (lamp_lit) begin
          lamp_lit = 1'b0;
          duty_aim = '0;
        end else begin
          lamp_lit = 1'b1;
          duty_aim = (duty_level > dimmer_regs.start_level) ? duty_level
                                                            : dimmer_regs.start_level;
        end
      end else if (key_latched && !it.key_down) begin
        key_latched = 1'b0;
      end
    end

    // fade: drive comes on as duty leaves 0, goes off only when a fall reaches 0
    if (duty_level != duty_aim) begin
      if (duty_aim < duty_level) begin
        if (fade_dwell_over()) duty_level--;
        if (duty_level == '0) drive_run = 1'b0;
      end else begin
        if (duty_level == '0) drive_run = 1'b1;
        if (fade_dwell_over()) duty_level++;
      end
    end

    // measurement: first conversion dropped, next SAMPLE_COUNT averaged by shift
    if (!series_active) begin
      if (series_ticks >= dimmer_regs.measure_period) begin
        series_ticks  = '0;
        series_idx    = '0;
        series_sum    = '0;
        series_active = 1'b1;
        started       = 1'b1;
      end
    end else if (it.conv_done) begin
      if (series_idx != '0) series_sum = series_sum + SUM_W'(it.conv_value);
      series_idx = series_idx + 5'd1;
      if (series_idx > SAMPLE_COUNT) begin
        series_active = 1'b0;
        series_ticks  = '0;
        series_sum    = series_sum >> SAMPLE_SHIFT;
        avg_reading   = series_sum;
        // regulator nudges the aim by one, only while the lamp is on
        if (lamp_lit) begin
          if (avg_reading > dimmer_regs.nominal_current && duty_aim > 0) duty_aim--;
          if (avg_reading < dimmer_regs.nominal_current && duty_aim < DUTY_MAX) duty_aim++;
        end
      end
    end

    r.duty             = duty_level;
    r.drive_enabled    = drive_run;
    r.lamp_on          = lamp_lit;
    r.start_conversion = started;
    r.sleep_now        = !lamp_lit && duty_level == '0 && !key_latched;
    r.average_current  = (avg_reading > CUR_MAX) ? CUR_MAX : avg_reading[CUR_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t stim_row(input bit t, k, c, input int v, input bit typed);
    dir_row_t row;
    row.stim.tick       = t;
    row.stim.key_down   = k;
    row.stim.conv_done  = c;
    row.stim.conv_value = CUR_W'(v);
    row.typed           = typed;
    return row;
  endfunction

  task automatic flag_readout(input string what);
    if (mismatch_count < 40) $display("%0t readout mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one pass, with random idle cycles first; the expectation is queued
  // at the edge where the transaction is taken.
  task automatic offer_pass(input item_t it, input logic typed);
    result_t want;
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.tick       <= it.tick;
    item_ch.key_down   <= it.key_down;
    item_ch.conv_done  <= it.conv_done;
    item_ch.conv_value <= it.conv_value;
    do @(posedge clk); while (!item_ch.ready);
    want = control_loop_pass(it);
    loop_results_due.push_back(typed ? AFTER_RESET : want);
  endtask

  // Sender stops and waits for every outstanding result.
  task automatic idle_until_drained();
    item_ch.valid <= 1'b0;
    while (loop_results_due.size() != 0) @(posedge clk);
  endtask

  // Write all eight registers; only called with nothing in flight. Spare upper
  // data bits of the narrow registers carry noise, which must be dropped.
  task automatic apply_settings(input cfg_t s);
    logic [CFG_DATA_W-1:0] word;
    for (int r = 0; r < 8; r++) begin
      case (CFG_IDX_W'(r))
        REG_NOMINAL_CURRENT: word = {6'($urandom), s.nominal_current};
        REG_START_LEVEL:     word = {8'($urandom), s.start_level};
        REG_BAND_LOW_TOP:    word = {8'($urandom), s.band_low_top};
        REG_BAND_MID_TOP:    word = {8'($urandom), s.band_mid_top};
        REG_DWELL_SLOW:      word = s.dwell_slow;
        REG_DWELL_MID:       word = s.dwell_mid;
        REG_DWELL_FAST:      word = s.dwell_fast;
        REG_MEASURE_PERIOD:  word = s.measure_period;
        default:             word = '0;
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_IDX_W'(r);
      cfg_ch.data  <= word;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    dimmer_regs = s;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, or a long hold-off counted here when asked for.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req      <= 1'b0;
      hold_left     <= HOLD_OFF_CYCLES;
      res_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      res_ch.ready  <= 1'b0;
    end else begin
      res_ch.ready  <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : readout_check
    result_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (loop_results_due.size() == 0) begin
        flag_readout("result transaction with no pass outstanding");
      end else begin
        want = loop_results_due.pop_front();
        if (res_ch.duty !== want.duty || res_ch.drive_enabled !== want.drive_enabled ||
            res_ch.lamp_on !== want.lamp_on ||
            res_ch.start_conversion !== want.start_conversion ||
            res_ch.sleep_now !== want.sleep_now ||
            res_ch.average_current !== want.average_current) begin
          flag_readout($sformatf(
            "duty %0d/%0d drive %b/%b lamp %b/%b start %b/%b sleep %b/%b avg %0d/%0d",
            res_ch.duty, want.duty, res_ch.drive_enabled, want.drive_enabled,
            res_ch.lamp_on, want.lamp_on, res_ch.start_conversion, want.start_conversion,
            res_ch.sleep_now, want.sleep_now, res_ch.average_current,
            want.average_current));
        end
      end
    end
  end

  // Watchdog: too long with no transaction on any channel ends the run.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    item_t      it;
    cfg_t       s;
    idle_mode_t mode;
    bit         key_level;
    int         v;

    rst_n              = 1'b0;
    item_ch.valid      = 1'b0;
    item_ch.tick       = 1'b0;
    item_ch.key_down   = 1'b0;
    item_ch.conv_done  = 1'b0;
    item_ch.conv_value = '0;
    res_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    key_level          = 1'b0;

    // With tick low nothing moves, so the first rows all show the reset
    // picture whatever the key does; a conversion outside a series is ignored.
    dir_rows[0]  = stim_row(0, 0, 0, 0, 1);
    dir_rows[1]  = stim_row(0, 1, 0, 0, 1);
    dir_rows[2]  = stim_row(0, 0, 1, 1023, 1);
    dir_rows[3]  = stim_row(0, 1, 1, 0, 1);
    dir_rows[4]  = stim_row(0, 1, 1, 'h2AA, 1);
    dir_rows[5]  = stim_row(0, 0, 1, 'h155, 1);
    dir_rows[6]  = stim_row(1, 0, 0, 0, 0);
    dir_rows[7]  = stim_row(1, 1, 1, 1023, 0);
    dir_rows[8]  = stim_row(1, 0, 1, 0, 0);
    // zero delays from here: a series opens at once, first conversion dropped,
    // eight more close it and the regulator acts
    dir_rows[9]  = stim_row(1, 1, 0, 0, 0);
    dir_rows[10] = stim_row(1, 0, 1, 1023, 0);
    dir_rows[11] = stim_row(0, 1, 1, 1023, 0);
    dir_rows[12] = stim_row(0, 0, 1, 1023, 0);
    dir_rows[13] = stim_row(1, 0, 1, 0, 0);
    dir_rows[14] = stim_row(0, 1, 1, 1023, 0);
    dir_rows[15] = stim_row(0, 0, 1, 'h2AA, 0);
    dir_rows[16] = stim_row(1, 1, 1, 'h155, 0);
    dir_rows[17] = stim_row(0, 0, 1, 1023, 0);
    dir_rows[18] = stim_row(1, 0, 1, 1023, 0);
    dir_rows[19] = stim_row(1, 0, 0, 0, 0);
    dir_rows[20] = stim_row(0, 0, 1, 0, 0);
    dir_rows[21] = stim_row(0, 1, 1, 0, 0);
    dir_rows[22] = stim_row(1, 0, 1, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // shadow state after reset: lamp on, aiming for the start level
    dimmer_regs.nominal_current = NOMINAL_RST;
    dimmer_regs.start_level     = START_RST;
    dimmer_regs.band_low_top    = LOW_TOP_RST;
    dimmer_regs.band_mid_top    = MID_TOP_RST;
    dimmer_regs.dwell_slow      = SLOW_RST;
    dimmer_regs.dwell_mid       = MID_RST;
    dimmer_regs.dwell_fast      = FAST_RST;
    dimmer_regs.measure_period  = PERIOD_RST;
    duty_level    = '0;
    duty_aim      = START_RST;
    lamp_lit      = 1'b1;
    drive_run     = 1'b0;
    key_latched   = 1'b0;
    series_active = 1'b0;
    series_idx    = '0;
    series_sum    = '0;
    fade_ticks    = '0;
    series_ticks  = '0;
    poll_ticks    = '0;
    avg_reading   = '0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_CFG_ROW) begin
        idle_until_drained();
        apply_settings(DIR_SETTINGS);
      end
      offer_pass(dir_rows[i].stim, dir_rows[i].typed);
    end

    // Random phases. Settings order: nominal, start, low top, mid top,
    // slow, mid, fast dwell, measure period.
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_until_drained();
      case (ph)
        0: s = {10'd512, 8'd64, 8'd32, 8'd128, 16'd3, 16'd2, 16'd1, 16'd5};
        // nominal at floor: regulator only lowers the aim
        1: s = {10'd0, 8'd200, 8'd100, 8'd150, 16'd1, 16'd1, 16'd0, 16'd2};
        // nominal at top, one band, everything at full speed
        2: s = {10'd1023, 8'd0, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0};
        // duty 0 cannot rise again within the phase, so the lamp toggles with the duty
        // stuck at 0 and the drive comes on with the lamp; no new series starts
        3: s = {10'd300, 8'd255, 8'd0, 8'd128, 16'd65535, 16'd0, 16'd0, 16'd65535};
        default: begin
          s.nominal_current = CUR_W'($urandom_range(1023));
          s.start_level     = DUTY_W'($urandom_range(255));
          s.band_low_top    = DUTY_W'($urandom_range(127));
          s.band_mid_top    = s.band_low_top + DUTY_W'($urandom_range(128));
          s.dwell_slow      = CNT_W'($urandom_range(3));
          s.dwell_mid       = CNT_W'($urandom_range(3));
          s.dwell_fast      = CNT_W'($urandom_range(3));
          s.measure_period  = CNT_W'($urandom_range(12));
        end
      endcase
      apply_settings(s);

      mode = idle_mode_t'(ph % 4);
      case (mode)
        IDLE_SENDER:   begin idle_pct = 78; stall_pct = 0;  end
        IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 78; end
        IDLE_BOTH:     begin idle_pct = 29; stall_pct = 29; end
        default:       begin idle_pct = 0;  stall_pct = 0;  end
      endcase

      for (int n = 0; n < PHASE_PASSES; n++) begin
        // back-pressure: receiver holds off while passes keep coming, so the
        // block fills and stalls its input; later the sender waits for all
        if (ph == PRESSURE_PHASE && n == 40) hold_req <= 1'b1;
        if (ph == PRESSURE_PHASE && n == 110) idle_until_drained();

        // key level held for stretches so that polls see presses and releases
        if ($urandom_range(39) == 0) key_level = !key_level;
        it.tick      = ($urandom_range(99) < 92);
        it.key_down  = key_level;
        it.conv_done = ($urandom_range(99) < 45);
        // readings mostly near nominal so the regulator moves both ways
        case ($urandom_range(3))
          0:       v = $urandom_range(1023);
          1, 2:    v = int'(dimmer_regs.nominal_current) + int'($urandom_range(16)) - 8;
          default: v = $urandom_range(1) ? 1023 : 0;
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        it.conv_value = CUR_W'(v);
        offer_pass(it, 1'b0);
      end
    end

    idle_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && loop_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
